### design/lcsfs_pkg.sv
// Package for the line comment strip field splitter.
// Holds shared constants, the controller state type and the command/status structs.
package lcsfs_pkg;

  localparam int BLOCK_COUNT_DEF = 16;
  localparam int LINE_CHARS_DEF  = 254;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_SEMI  = 8'd59;

  localparam logic [1:0] MODE_MULTI  = 2'd0;
  localparam logic [1:0] MODE_FINAL  = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;

  localparam logic [2:0] REG_DELIM0  = 3'd0;
  localparam logic [2:0] REG_DELIM1  = 3'd1;
  localparam logic [2:0] REG_DELIM2  = 3'd2;
  localparam logic [2:0] REG_DELIM3  = 3'd3;
  localparam logic [2:0] REG_COMMENT = 3'd4;
  localparam logic [2:0] REG_FINAL   = 3'd5;
  localparam logic [2:0] REG_MODE    = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRD,
    ST_CCHK,
    ST_SRD,
    ST_SCHK,
    ST_TAIL
  } lcsfs_state_t;

  typedef struct packed {
    logic store;       // write the accepted byte into the line store
    logic line_end;    // latch the trimmed length, bump the line number
    logic rd;          // read the line store at the scan position
    logic pos_inc;     // advance the scan position
    logic cmt_cut;     // comment found: length becomes the scan position
    logic split_init;  // restart the scan for splitting
    logic emit_hit;    // emit a field that ends at a delimiter
    logic emit_tail;   // emit the field after the last delimiter
    logic emit_empty;  // emit the no-field result
  } lcsfs_cmd_t;

  typedef struct packed {
    logic line_done;   // accepted item ends the line
    logic cmt_end;     // comment scan reached the trimmed length
    logic cmt_match;   // byte read is the comment byte
    logic scan_end;    // split scan reached the length
    logic hit;         // byte read splits the line here
    logic out_busy;    // result register holds an item not taken
    logic tail_left;   // bytes remain after the last delimiter
    logic count_zero;  // no field emitted yet
  } lcsfs_stat_t;

endpackage

### design/line_comment_strip_field_splitter_top.sv
// Top level of the line comment strip field splitter.
// Depends on lcsfs_pkg, lcsfs_ctrl and lcsfs_dp.
//
// Usage: text bytes enter on the in_ channel one item at a time. Each byte is
// written into the line store. A line ends at a newline byte, at an item with
// in_close_line set (its byte is not stored), or when the store holds
// LINE_CHARS bytes. At line end the trailing CR, LF, space and tab bytes are
// already dropped from the length, and the line is scanned once for the comment
// byte and once more for delimiters, each byte read from the store in turn.
// Each field leaves on the out_ channel as one item; an empty line gives a
// single item with out_no_fields set.
// Throughput: one byte per cycle while a line loads. The item that ends a line
// starts a scan that holds in_stall high until it returns to idle, also while
// a stalled result holds it up: the single read port reads a byte and checks
// it the next cycle.
// A stalled result holds in the output register; the scan waits only when
// a further field is ready and the register is still full.
// Reset (rst_n low at a clock edge) clears the line number, fill count and
// configuration to defaults: comment byte ';', no delimiters, multi split.
// Configuration registers sit at byte addresses 8*i on the 64-bit port.
module line_comment_strip_field_splitter_top
  import lcsfs_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int LINE_CHARS  = LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_close_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_line_count,
  output logic [5:0]  out_field_index,
  output logic [7:0]  out_field_start,
  output logic [7:0]  out_field_length,
  output logic        out_no_fields,
  output logic        out_last_field
);

  lcsfs_cmd_t  cmd;
  lcsfs_stat_t stat;

  // The register port never waits.
  assign pready = 1'b1;

  lcsfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lcsfs_dp #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .LINE_CHARS  (LINE_CHARS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .in_data_byte     (in_data_byte),
    .in_close_line    (in_close_line),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_count   (out_line_count),
    .out_field_index  (out_field_index),
    .out_field_start  (out_field_start),
    .out_field_length (out_field_length),
    .out_no_fields    (out_no_fields),
    .out_last_field   (out_last_field),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

### design/lcsfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lcsfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 254
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lcsfs_ctrl.sv
// Controller state machine: load, comment scan, split scan and tail emission.
// Depends on lcsfs_pkg.
module lcsfs_ctrl
  import lcsfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  lcsfs_stat_t stat,
  output lcsfs_cmd_t  cmd
);

  lcsfs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (stat.line_done) begin
            cmd.line_end = 1'b1;
            state_nxt    = ST_CRD;
          end
        end
      end
      ST_CRD: begin
        if (stat.cmt_end) begin
          cmd.split_init = 1'b1;
          state_nxt      = ST_SRD;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CCHK;
        end
      end
      ST_CCHK: begin
        if (stat.cmt_match) begin
          cmd.cmt_cut    = 1'b1;
          cmd.split_init = 1'b1;
          state_nxt      = ST_SRD;
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = ST_CRD;
        end
      end
      ST_SRD: begin
        if (stat.scan_end) begin
          state_nxt = ST_TAIL;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (stat.hit) begin
          if (!stat.out_busy) begin
            cmd.emit_hit = 1'b1;
            cmd.pos_inc  = 1'b1;
            state_nxt    = ST_SRD;
          end
        end else begin
          cmd.pos_inc = 1'b1;
          state_nxt   = ST_SRD;
        end
      end
      ST_TAIL: begin
        if (stat.tail_left) begin
          if (!stat.out_busy) begin
            cmd.emit_tail = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (stat.count_zero) begin
          if (!stat.out_busy) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hit || cmd.emit_tail || cmd.emit_empty) |-> !stat.out_busy)
    else $error("result emitted over an item not yet taken");
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.emit_hit, cmd.emit_tail, cmd.emit_empty}) <= 1)
    else $error("two results emitted at once");
  a_idle_after_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_tail || cmd.emit_empty) |=> state_r == ST_IDLE)
    else $error("line end did not return to idle");
`endif

endmodule

### design/lcsfs_dp.sv
// Datapath: configuration registers, line store, scan counters and result register.
// Depends on lcsfs_pkg and lcsfs_ram.
module lcsfs_dp
  import lcsfs_pkg::*;
#(
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
  parameter int LINE_CHARS  = LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  input  logic [7:0]  in_data_byte,
  input  logic        in_close_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_line_count,
  output logic [5:0]  out_field_index,
  output logic [7:0]  out_field_start,
  output logic [7:0]  out_field_length,
  output logic        out_no_fields,
  output logic        out_last_field,
  input  lcsfs_cmd_t  cmd,
  output lcsfs_stat_t stat
);

  localparam int AW = $clog2(LINE_CHARS);
  localparam int CW = $clog2(BLOCK_COUNT);

  logic [63:0] delim_r [4];
  logic [7:0]  comment_r, final_r;
  logic [1:0]  mode_r;

  logic [7:0]  fill_r, trim_r, len_r, pos_r, first_r;
  logic [CW-1:0] count_r;
  logic        stop_r;
  logic [31:0] line_r;
  logic [7:0]  rdata;
  logic [2:0]  reg_idx;
  logic        ws, is_delim, stopper;

  logic        ov_r;
  logic [31:0] o_line_r;
  logic [5:0]  o_idx_r;
  logic [7:0]  o_start_r, o_len_r;
  logic        o_none_r, o_last_r;

  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r[0] <= '0;
      delim_r[1] <= '0;
      delim_r[2] <= '0;
      delim_r[3] <= '0;
      comment_r  <= CH_SEMI;
      final_r    <= '0;
      mode_r     <= MODE_MULTI;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_DELIM0:  delim_r[0] <= pwdata;
        REG_DELIM1:  delim_r[1] <= pwdata;
        REG_DELIM2:  delim_r[2] <= pwdata;
        REG_DELIM3:  delim_r[3] <= pwdata;
        REG_COMMENT: comment_r  <= pwdata[7:0];
        REG_FINAL:   final_r    <= pwdata[7:0];
        REG_MODE:    mode_r     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELIM0:  prdata = delim_r[0];
      REG_DELIM1:  prdata = delim_r[1];
      REG_DELIM2:  prdata = delim_r[2];
      REG_DELIM3:  prdata = delim_r[3];
      REG_COMMENT: prdata = {56'd0, comment_r};
      REG_FINAL:   prdata = {56'd0, final_r};
      REG_MODE:    prdata = {62'd0, mode_r};
      default:     prdata = '0;
    endcase
  end

  lcsfs_ram #(.WIDTH(8), .DEPTH(LINE_CHARS)) u_store (
    .clk   (clk),
    .we    (cmd.store && !in_close_line),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_data_byte),
    .re    (cmd.rd),
    .raddr (pos_r[AW-1:0]),
    .rdata (rdata)
  );

  assign ws = (in_data_byte == CH_CR) || (in_data_byte == CH_LF) ||
              (in_data_byte == CH_SPACE) || (in_data_byte == CH_TAB);
  assign is_delim = delim_r[rdata[7:6]][rdata[5:0]];
  assign stopper  = (mode_r == MODE_SINGLE) || (mode_r == MODE_FINAL && rdata == final_r);

  assign stat.line_done  = in_close_line || in_data_byte == CH_LF ||
                           fill_r == 8'(LINE_CHARS - 1);
  assign stat.cmt_end    = pos_r >= len_r;
  assign stat.cmt_match  = comment_r != 8'd0 && rdata == comment_r;
  assign stat.scan_end   = pos_r >= len_r;
  assign stat.hit        = is_delim && !stop_r && count_r != CW'(BLOCK_COUNT - 1);
  assign stat.out_busy   = ov_r && out_stall;
  assign stat.tail_left  = first_r < len_r;
  assign stat.count_zero = count_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      trim_r  <= '0;
      line_r  <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      first_r <= '0;
      count_r <= '0;
      stop_r  <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (cmd.line_end) begin
          fill_r  <= '0;
          trim_r  <= '0;
          line_r  <= line_r + 32'd1;
          len_r   <= (!in_close_line && !ws) ? fill_r + 8'd1 : trim_r;
          pos_r   <= '0;
        end else begin
          fill_r <= fill_r + 8'd1;
          if (!ws) begin
            trim_r <= fill_r + 8'd1;
          end
        end
      end
      if (cmd.cmt_cut) begin
        len_r <= pos_r;
      end
      if (cmd.split_init) begin
        pos_r   <= '0;
        first_r <= '0;
        count_r <= '0;
        stop_r  <= 1'b0;
      end else if (cmd.pos_inc) begin
        pos_r <= pos_r + 8'd1;
      end
      if (cmd.emit_hit) begin
        first_r <= pos_r + 8'd1;
        count_r <= count_r + CW'(1);
        if (stopper) begin
          stop_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_hit || cmd.emit_tail || cmd.emit_empty) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit || cmd.emit_tail || cmd.emit_empty) begin
      o_line_r <= line_r;
      o_none_r <= cmd.emit_empty;
      if (cmd.emit_empty) begin
        o_idx_r   <= '0;
        o_start_r <= '0;
        o_len_r   <= '0;
        o_last_r  <= 1'b1;
      end else if (cmd.emit_hit) begin
        o_idx_r   <= 6'(count_r);
        o_start_r <= first_r;
        o_len_r   <= pos_r - first_r;
        o_last_r  <= (pos_r + 8'd1) == len_r;
      end else begin
        o_idx_r   <= 6'(count_r);
        o_start_r <= first_r;
        o_len_r   <= len_r - first_r;
        o_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_line_count   = o_line_r;
  assign out_field_index  = o_idx_r;
  assign out_field_start  = o_start_r;
  assign out_field_length = o_len_r;
  assign out_no_fields    = o_none_r;
  assign out_last_field   = o_last_r;

`ifndef SYNTHESIS
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_none_r) |-> o_last_r)
    else $error("no-field result not marked last");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(BLOCK_COUNT - 1))
    else $error("field count past its limit");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_hit |-> (pos_r < len_r && first_r <= pos_r))
    else $error("delimiter field outside the line");
`endif

endmodule

### dv/field_split_checker.sv
`timescale 1ns / 1ps
// Checker for the line comment strip field splitter: watches both channels,
// predicts the fields of each finished line and compares them. Uses lcsfs_pkg.
module field_split_checker
  import lcsfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_close_line,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_line_count,
  input  logic [5:0]  out_field_index,
  input  logic [7:0]  out_field_start,
  input  logic [7:0]  out_field_length,
  input  logic        out_no_fields,
  input  logic        out_last_field,
  output int          fail_count,
  output int          pending_fields
);

  typedef struct packed {
    logic [31:0] line_count;
    logic [5:0]  index;
    logic [7:0]  start;
    logic [7:0]  length;
    logic        no_fields;
    logic        last;
  } field_t;

  field_t      field_q[$];
  logic [63:0] delim_map[4];
  logic [7:0]  comment_byte;
  logic [7:0]  final_byte;
  logic [1:0]  mode;
  logic [7:0]  line_buf[LINE_CHARS_DEF];
  int          fill;
  logic [31:0] line_num;

  assign pending_fields = field_q.size();

  function automatic bit is_delim(logic [7:0] b);
    return delim_map[b[7:6]][b[5:0]];
  endfunction

  task automatic push_field(int k, int start, int len, bit last);
    field_t f;
    f.line_count = line_num;
    f.index      = k[5:0];
    f.start      = start[7:0];
    f.length     = len[7:0];
    f.no_fields  = 1'b0;
    f.last       = last;
    field_q.push_back(f);
  endtask

  // Trims, cuts at the comment byte and splits the stored line.
  task automatic split_line();
    int len;
    int first;
    int cnt;
    int hit;
    int starts[BLOCK_COUNT_DEF];
    int lens[BLOCK_COUNT_DEF];
    field_t f;
    len = fill;
    first = 0;
    cnt = 0;
    line_num = line_num + 1;
    while (len > 0 && (line_buf[len-1] == CH_CR || line_buf[len-1] == CH_LF ||
           line_buf[len-1] == CH_SPACE || line_buf[len-1] == CH_TAB))
      len--;
    if (comment_byte != 8'd0) begin
      for (int p = 0; p < len; p++) begin
        if (line_buf[p] == comment_byte) begin
          len = p;
          break;
        end
      end
    end
    while (cnt < BLOCK_COUNT_DEF - 1) begin
      hit = len;
      for (int p = first; p < len; p++) begin
        if (is_delim(line_buf[p])) begin
          hit = p;
          break;
        end
      end
      if (hit >= len) break;
      starts[cnt] = first;
      lens[cnt] = hit - first;
      cnt++;
      first = hit + 1;
      if (mode == MODE_SINGLE) break;
      if (mode == MODE_FINAL && line_buf[hit] == final_byte) break;
    end
    if (first < len) begin
      starts[cnt] = first;
      lens[cnt] = len - first;
      cnt++;
    end
    fill = 0;
    if (cnt == 0) begin
      f = '0;
      f.line_count = line_num;
      f.no_fields = 1'b1;
      f.last = 1'b1;
      field_q.push_back(f);
    end else begin
      for (int k = 0; k < cnt; k++) push_field(k, starts[k], lens[k], k == cnt - 1);
    end
  endtask

  always @(posedge clk) begin
    field_t got;
    field_t want;
    if (!rst_n) begin
      delim_map = '{default: 64'd0};
      comment_byte = CH_SEMI;
      final_byte = 8'd0;
      mode = MODE_MULTI;
      fill = 0;
      line_num = 32'd0;
      fail_count = 0;
      field_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_DELIM0, REG_DELIM1, REG_DELIM2, REG_DELIM3:
            delim_map[paddr[4:3]] = pwdata;
          REG_COMMENT: comment_byte = pwdata[7:0];
          REG_FINAL:   final_byte = pwdata[7:0];
          REG_MODE:    mode = pwdata[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_close_line) begin
          split_line();
        end else begin
          if (fill < LINE_CHARS_DEF) begin
            line_buf[fill] = in_data_byte;
            fill++;
          end
          if (in_data_byte == CH_LF || fill >= LINE_CHARS_DEF) split_line();
        end
      end
      if (out_valid && !out_stall) begin
        got = {out_line_count, out_field_index, out_field_start, out_field_length,
               out_no_fields, out_last_field};
        if (field_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected field %h", got);
        end else begin
          want = field_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("field mismatch: expected line %0d idx %0d start %0d len %0d nf %b last %b, got line %0d idx %0d start %0d len %0d nf %b last %b",
                       want.line_count, want.index, want.start, want.length,
                       want.no_fields, want.last, got.line_count, got.index,
                       got.start, got.length, got.no_fields, got.last);
          end
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for line_comment_strip_field_splitter_top: makes text
// stimulus and configuration writes; field_split_checker judges the results.
module tb;
  import lcsfs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_close_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_line_count;
  logic [5:0]  out_field_index;
  logic [7:0]  out_field_start;
  logic [7:0]  out_field_length;
  logic        out_no_fields;
  logic        out_last_field;
  int          fail_count;
  int          pending_fields;
  int          cycle_count = 0;
  // Idle percentage of each side; zero during the calm stretch.
  int          in_idle_pct = 10;
  int          out_idle_pct = 10;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_comment_strip_field_splitter_top i_dut (.*);

  field_split_checker i_checker (.*);

  // Receiver stalls at random; a stalled result must hold in the block.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // The run is bounded: past its cycle limit it ends as failed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("line_comment_strip_field_splitter_top test failed");
      $finish;
    end
  end

  // One APB write: setup cycle, then the access cycle that commits it.
  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Sends one item and holds it until the block takes it. Valid stays high
  // from one item to the next, so it is lowered only for a random gap.
  // The stall seen at the edge itself decides whether the item was taken.
  task automatic send_item(logic [7:0] b, logic close);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_close_line <= close;
    @(posedge clk iff !in_stall);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // Waits for every predicted field, then lets the scan of a line that
  // produced nothing yet run out before a register may change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields != 0 || in_stall) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Random byte leaning toward the active delimiters, comment byte and
  // trailing whitespace so that real field structure appears.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0: return ",";
      1: return " ";
      2: return ";";
      3: return 8'd9;
      4: return 8'd13;
      5: return ":";
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic random_lines(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      // Mostly short lines; now and then a full store.
      len = ($urandom_range(19) == 0) ? 260 : $urandom_range(30);
      for (int i = 0; i < len && sent < n_items; i++) begin
        send_item(pick_byte(), 1'b0);
        sent++;
      end
      if ($urandom_range(3) == 0) send_item(8'($urandom_range(255)), 1'b1);
      else send_item(CH_LF, 1'b0);
      sent++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no delimiters, so each line is one field or none.
    send_text("abc ;x\n");
    send_text(" \t\r \n");
    send_item(8'd0, 1'b1);
    send_text("q");
    send_item(8'hFF, 1'b1);
    drain();

    // Comma and colon split in multi mode, comment disabled, bytes 0 and 0xFF delimiters.
    write_reg(REG_DELIM0, 64'h0400_1000_0000_0001);
    write_reg(REG_DELIM1, 64'd0);
    write_reg(REG_DELIM2, 64'd0);
    write_reg(REG_DELIM3, 64'h8000_0000_0000_0000);
    write_reg(REG_COMMENT, 64'd0);
    write_reg(REG_FINAL, ":");
    write_reg(REG_MODE, {62'd0, MODE_MULTI});
    send_text(",a,,b:c;d,\n");
    send_item(8'd0, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text(",,,,,,,,,,,,,,,,,,,,\n");
    drain();

    write_reg(REG_MODE, {62'd0, MODE_FINAL});
    send_text("a,b:c,d\n");
    drain();
    write_reg(REG_MODE, 64'd0);
    write_reg(REG_MODE, {62'd0, MODE_SINGLE});
    write_reg(REG_COMMENT, {56'd0, CH_SEMI});
    send_text("a,b,c;z\n");
    drain();

    // Mode three acts as multi split; delimiter maps 1 and 2 fully set.
    write_reg(REG_MODE, 64'd3);
    write_reg(REG_DELIM1, '1);
    write_reg(REG_DELIM2, '1);
    send_text("x,y@z\n");
    random_lines(45);
    drain();

    // Long calm stretch with no idling on either side.
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(REG_DELIM1, 64'd0);
    write_reg(REG_DELIM2, 64'd0);
    write_reg(REG_MODE, {62'd0, MODE_MULTI});
    write_reg(REG_COMMENT, 64'hFF);
    random_lines(55);
    drain();

    in_idle_pct = 10;
    out_idle_pct = 10;
    write_reg(REG_MODE, {62'd0, MODE_FINAL});
    write_reg(REG_FINAL, ",");
    write_reg(REG_COMMENT, {56'd0, CH_SEMI});
    random_lines(55);
    drain();

    write_reg(REG_MODE, {62'd0, MODE_SINGLE});
    write_reg(REG_DELIM0, {$urandom, $urandom});
    write_reg(REG_DELIM3, {$urandom, $urandom});
    random_lines(45);
    drain();

    if (fail_count == 0) begin
      $display("line_comment_strip_field_splitter_top test passed");
    end else begin
      $display("line_comment_strip_field_splitter_top test failed");
    end
    $finish;
  end

endmodule

### sim.f
design/lcsfs_pkg.sv
design/lcsfs_ram.sv
design/lcsfs_ctrl.sv
design/lcsfs_dp.sv
design/line_comment_strip_field_splitter_top.sv
dv/field_split_checker.sv
dv/tb.sv
